@@ rtl/core/lpcv_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcv_pkg
// Shared types, constants and a helper function of the page/column LCD
// controller: screen geometry, command codes and the queue entry format.
// ----------------------------------------------------------------------------
package lpcv_pkg;

  // Visible screen size in pixels.
  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 88;

  // Display memory geometry: 16 pages of 256 bytes, held as two banks of
  // 16 x 128 bytes (even and odd byte addresses).
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned ROW_W    = 7;
  localparam int unsigned MEM_AW   = PAGE_W + ROW_W;
  localparam int unsigned BIT_W    = 3;

  // Page of the rightmost group of eight columns in the rotated pixel mapping.
  localparam logic [PAGE_W-1:0] PAGE_OFFSET = 4'd10;

  // Command codes, taken from the upper nibble of the reversed bus byte.
  localparam logic [3:0] CMD_COL_LO = 4'h0;
  localparam logic [3:0] CMD_COL_HI = 4'h1;
  localparam logic [3:0] CMD_PAGE   = 4'hb;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_kind_e;

  // One entry of the queue between the front and back parts.
  typedef struct packed {
    op_kind_e          kind;
    logic [MEM_AW-1:0] addr;     // {page, byte address / 2} or {page, row}
    logic              odd;      // writes: odd bank selected
    logic [7:0]        data;     // writes: reversed byte
    logic [BIT_W-1:0]  bit_sel;  // reads: bit within both bytes
    logic              in_range; // reads: pixel lies on the screen
  } op_t;

  // Queue fill status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Back part status.
  typedef struct packed {
    logic init_done;
    logic pop;
  } back_stat_t;

  function automatic logic [7:0] reverse_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/lpcv_fifo.sv @@
// ----------------------------------------------------------------------------
// lpcv_fifo
// Two-entry queue of decoded memory operations between front and back.
// ----------------------------------------------------------------------------
module lpcv_fifo
  import lpcv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  op_t        push_op_i,
  input  logic       pop_i,
  output op_t        head_o,
  output fifo_stat_t stat_o
);

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = count_q[1];
  assign stat_o.empty = (count_q == 2'd0);

endmodule

@@ rtl/core/lpcv_front.sv @@
// ----------------------------------------------------------------------------
// lpcv_front
// Accepts bus writes and pixel reads, keeps the column and page registers,
// and turns data writes and reads into queued memory operations.
// ----------------------------------------------------------------------------
module lpcv_front
  import lpcv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic        is_data_i,
  input  logic [7:0]  bus_byte_i,
  input  logic [6:0]  pixel_x_i,
  input  logic [6:0]  pixel_y_i,
  input  fifo_stat_t  fifo_stat_i,
  input  logic        init_done_i,
  output logic        push_o,
  output op_t         push_op_o
);

  logic [7:0]        byte_addr_q, byte_addr_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [7:0]        rev;
  logic              accept;
  logic [6:0]        col_dist;
  logic              x_ok, y_ok;

  assign in_ready_o = init_done_i && !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign rev        = reverse_byte(bus_byte_i);

  // Columns are counted from the right edge of the screen.
  assign col_dist = 7'(8'(SCREEN_WIDTH - 1) - {1'b0, pixel_x_i});
  assign x_ok     = ({1'b0, pixel_x_i} < 8'(SCREEN_WIDTH));
  assign y_ok     = ({1'b0, pixel_y_i} < 8'(SCREEN_HEIGHT));

  always_comb begin
    byte_addr_d = byte_addr_q;
    page_d      = page_q;
    if (accept && !mode_i) begin
      if (is_data_i) begin
        byte_addr_d = byte_addr_q + 8'd1;
      end else begin
        case (rev[7:4])
          CMD_COL_LO: byte_addr_d = (byte_addr_q & 8'he0) | {3'b000, rev[3:0], 1'b0};
          CMD_COL_HI: byte_addr_d = (byte_addr_q & 8'h1e) | {rev[2:0], 5'b00000};
          CMD_PAGE:   page_d      = rev[3:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_addr_q <= 8'd0;
      page_q      <= '0;
    end else begin
      byte_addr_q <= byte_addr_d;
      page_q      <= page_d;
    end
  end

  always_comb begin
    push_op_o = '0;
    if (mode_i) begin
      push_op_o.kind     = OP_READ;
      push_op_o.addr     = {col_dist[6:3] + PAGE_OFFSET, pixel_y_i};
      push_op_o.bit_sel  = col_dist[2:0];
      push_op_o.in_range = x_ok && y_ok;
    end else begin
      push_op_o.kind = OP_WRITE;
      push_op_o.addr = {page_q, byte_addr_q[7:1]};
      push_op_o.odd  = byte_addr_q[0];
      push_op_o.data = rev;
    end
  end

  assign push_o = accept && (mode_i || is_data_i);

endmodule

@@ rtl/core/lpcv_back.sv @@
// ----------------------------------------------------------------------------
// lpcv_back
// Display memory in two byte banks, its clearing pass after reset, the
// registered read stage and the output register.
// ----------------------------------------------------------------------------
module lpcv_back
  import lpcv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        head_i,
  input  fifo_stat_t fifo_stat_i,
  output back_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] pixel_level_o
);

  logic [7:0] even_mem [2**MEM_AW];
  logic [7:0] odd_mem  [2**MEM_AW];

  logic              clearing_q, clearing_d;
  logic [MEM_AW-1:0] clr_addr_q, clr_addr_d;

  logic [7:0]       rd_even_q, rd_odd_q;
  logic             rd_valid_q, rd_valid_d;
  logic [BIT_W-1:0] rd_bit_q;
  logic             rd_in_range_q;

  logic       out_valid_q, out_valid_d;
  logic [1:0] level_q;

  logic              advance, pop, issue_rd, issue_wr;
  logic              we_even, we_odd;
  logic [MEM_AW-1:0] waddr;
  logic [7:0]        wdata;

  assign advance  = !out_valid_q || out_ready_i;
  assign pop      = !clearing_q && !fifo_stat_i.empty &&
                    ((head_i.kind == OP_WRITE) || !rd_valid_q || advance);
  assign issue_rd = pop && (head_i.kind == OP_READ);
  assign issue_wr = pop && (head_i.kind == OP_WRITE);

  always_comb begin
    waddr   = clearing_q ? clr_addr_q : head_i.addr;
    wdata   = clearing_q ? 8'd0 : head_i.data;
    we_even = clearing_q || (issue_wr && !head_i.odd);
    we_odd  = clearing_q || (issue_wr && head_i.odd);
  end

  always_comb begin
    clr_addr_d = clearing_q ? clr_addr_q + 1'b1 : clr_addr_q;
    clearing_d = clearing_q && (clr_addr_q != '1);
  end

  always_comb begin
    rd_valid_d = rd_valid_q;
    if (issue_rd) begin
      rd_valid_d = 1'b1;
    end else if (advance) begin
      rd_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = rd_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_addr_q  <= clr_addr_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_even) begin
      even_mem[waddr] <= wdata;
    end
    if (we_odd) begin
      odd_mem[waddr] <= wdata;
    end
    if (issue_rd) begin
      rd_even_q <= even_mem[head_i.addr];
      rd_odd_q  <= odd_mem[head_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_rd) begin
      rd_bit_q      <= head_i.bit_sel;
      rd_in_range_q <= head_i.in_range;
    end
    if (advance && rd_valid_q) begin
      level_q <= rd_in_range_q ? {rd_even_q[rd_bit_q], rd_odd_q[rd_bit_q]} : 2'd0;
    end
  end

  assign stat_o.init_done = !clearing_q;
  assign stat_o.pop       = pop;
  assign out_valid_o      = out_valid_q;
  assign pixel_level_o    = level_q;

endmodule

@@ rtl/core/lcd_page_column_vram_controller.sv @@
// ----------------------------------------------------------------------------
// lcd_page_column_vram_controller
// Read path: a pixel read passes the queue, the registered read stage and
// the output register before out_valid_o shows it; bus writes give no result.
// Throughput: one transaction per cycle while in_ready_o is high, set by the
// single write or read port of each display memory bank.
// Reset: column, page and handshake state clear at once; a clearing pass then
// zeroes all 2048 rows of both memory banks, with in_ready_o held low.
// ----------------------------------------------------------------------------
module lcd_page_column_vram_controller
  import lpcv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       mode_i,
  input  logic       is_data_i,
  input  logic [7:0] bus_byte_i,
  input  logic [6:0] pixel_x_i,
  input  logic [6:0] pixel_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] pixel_level_o
);

  // The front part decodes every input transaction. Commands only touch the
  // column and page registers there; data bytes and pixel reads become
  // memory operations that travel through a short queue, so memory order
  // always follows acceptance order and a read sees all earlier writes.
  logic       push;
  op_t        push_op;
  op_t        head;
  fifo_stat_t fifo_stat;
  back_stat_t back_stat;

  lpcv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .is_data_i   (is_data_i),
    .bus_byte_i  (bus_byte_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .fifo_stat_i (fifo_stat),
    .init_done_i (back_stat.init_done),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  // The queue lets a stalled result output hold back reads without blocking
  // acceptance until the queue is full.
  lpcv_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (back_stat.pop),
    .head_o    (head),
    .stat_o    (fifo_stat)
  );

  // The back part owns the memory, its clearing pass, a registered read
  // stage and the output register that parts it from the consumer.
  lpcv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_stat_i   (fifo_stat),
    .stat_o        (back_stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_level_o (pixel_level_o)
  );

`ifndef NO_ASSERTIONS
  // No transaction enters while the memory is still being cleared.
  a_no_accept_in_init : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !back_stat.init_done |-> !(in_valid_i && in_ready_o)
  ) else $error("transaction accepted during memory clearing");

  // The queue is never pushed while full.
  a_no_overflow : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> !push
  ) else $error("operation queue overflow");

  // The back part never pops an empty queue.
  a_no_underflow : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !fifo_stat.empty
  ) else $error("operation queue underflow");

  // Once clearing is done, it never starts again without reset.
  a_init_stays_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    back_stat.init_done |=> back_stat.init_done
  ) else $error("memory clearing restarted");
`endif

endmodule

@@ sim/tb_lcd_page_column_vram_controller.sv @@
// ----------------------------------------------------------------------------
// tb_lcd_page_column_vram_controller
// Self-checking testbench of the page/column LCD controller. A directed
// table covers empty memory, screen edges, off-screen pixels, every command
// and the byte address wrap. Random bus sequences and pixel reads follow.
// Reads are checked against table levels or a local display memory model.
// ----------------------------------------------------------------------------
module tb_lcd_page_column_vram_controller
  import lpcv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ITEMS     = 2000;
  localparam int unsigned QUIET_ITEMS = 200;
  // Cycles without any accepted transaction or result before the run is declared
  // hung. The clearing pass after reset counts toward the limit.
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 10;
  // Upper nibble of a command that the controller ignores.
  localparam logic [3:0]  CMD_UNUSED  = 4'hf;

  // One row of the directed table. Where chk is set, lvl is the expected
  // pixel level; every other read is checked against the model.
  typedef struct {
    op_kind_e   mode;
    logic       is_data;
    logic [7:0] bus;
    logic [6:0] x;
    logic [6:0] y;
    logic       chk;
    logic [1:0] lvl;
  } dir_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b1;
  logic       in_valid_i    = 1'b0;
  logic       mode_i        = 1'b0;
  logic       is_data_i     = 1'b0;
  logic [7:0] bus_byte_i    = 8'h00;
  logic [6:0] pixel_x_i     = 7'd0;
  logic [6:0] pixel_y_i     = 7'd0;
  logic       out_ready_i   = 1'b1;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] pixel_level_o;

  // Model of the controller: display memory, byte address and page.
  logic [7:0] shadow_mem [4096];
  logic [7:0] addr_ptr;
  logic [3:0] page_ptr;

  // Pixel levels still owed by the block, oldest first.
  logic [1:0] pending_levels [$];

  int unsigned err_cnt  = 0;
  int unsigned sent_cnt = 0;
  int unsigned idle_cnt = 0;
  bit          quiet    = 1'b0;

  always #5 clk_i = ~clk_i;

  lcd_page_column_vram_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .is_data_i     (is_data_i),
    .bus_byte_i    (bus_byte_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_level_o (pixel_level_o)
  );

  // The bus wires are crossed: bit 0 of the processor lands on bit 7.
  function automatic logic [7:0] flip_byte(input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      r = {r[6:0], b[i]};
    end
    return r;
  endfunction

  // Screen columns run right to left through the pages, eight per page,
  // starting at page PAGE_OFFSET. Each row uses an even and an odd byte.
  function automatic logic [1:0] predict_pixel(input logic [6:0] x, input logic [6:0] y);
    int unsigned d;
    int unsigned bsel;
    int unsigned pg;
    int unsigned base;
    if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
      return 2'd0;
    end
    d    = SCREEN_WIDTH - 1 - x;
    bsel = d % 8;
    pg   = (d / 8 + PAGE_OFFSET) % 16;
    base = pg * 256 + ((2 * y) % 256);
    return {shadow_mem[base][bsel], shadow_mem[base + 1][bsel]};
  endfunction

  // Advances the model by one accepted transaction.
  task automatic apply_item(input op_kind_e m, input logic dc, input logic [7:0] bus,
                            input logic [6:0] x, input logic [6:0] y,
                            input logic chk, input logic [1:0] lvl);
    logic [7:0] r;
    r = flip_byte(bus);
    if (m == OP_READ) begin
      pending_levels.push_back(chk ? lvl : predict_pixel(x, y));
    end else if (dc) begin
      shadow_mem[{page_ptr, addr_ptr}] = r;
      addr_ptr = addr_ptr + 8'd1;
    end else begin
      case (r[7:4])
        CMD_COL_LO: addr_ptr = {addr_ptr[7:5], r[3:0], 1'b0};
        CMD_COL_HI: addr_ptr = {r[2:0], addr_ptr[4:1], 1'b0};
        CMD_PAGE:   page_ptr = r[3:0];
        default:    ;
      endcase
    end
  endtask

  // Presents one transaction and holds it until it is accepted. Called at a
  // rising edge; returns at the edge that accepted the transaction.
  task automatic send(input op_kind_e m, input logic dc, input logic [7:0] bus,
                      input logic [6:0] x, input logic [6:0] y,
                      input logic chk, input logic [1:0] lvl);
    bit fire;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    is_data_i  <= dc;
    bus_byte_i <= bus;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    // Handshake inputs only move at rising edges, so the falling edge shows
    // exactly what the next rising edge will see.
    do begin
      @(negedge clk_i);
      fire = in_ready_o;
      if (fire) begin
        apply_item(m, dc, bus, x, y, chk, lvl);
      end
      @(posedge clk_i);
    end while (!fire);
    sent_cnt++;
  endtask

  // Bus write given by its reversed byte; the pixel fields carry noise.
  task automatic write_byte(input logic dc, input logic [7:0] r);
    send(OP_WRITE, dc, flip_byte(r), 7'($urandom_range(0, 127)),
         7'($urandom_range(0, 127)), 1'b0, 2'd0);
  endtask

  // Pixel read; the write fields carry noise.
  task automatic read_px(input logic [6:0] x, input logic [6:0] y);
    send(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), x, y, 1'b0, 2'd0);
  endtask

  // Result side: compare every accepted result with the oldest expectation.
  // The watchdog shares the falling-edge view of both handshakes.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_levels.size() == 0) begin
        $error("pixel_level: result with no transaction pending, actual %0d", pixel_level_o);
        err_cnt++;
      end else begin
        if (pixel_level_o !== pending_levels[0]) begin
          $error("pixel_level mismatch: expected %0d, actual %0d",
                 pending_levels[0], pixel_level_o);
          err_cnt++;
        end
        void'(pending_levels.pop_front());
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("tb_lcd_page_column_vram_controller NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts until the final quiet stretch.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t    dir_tab [24];
    int unsigned kind;
    int unsigned n;
    logic [3:0]  grp;
    bit          paused;

    // Reset goes low once every process is waiting, so the block sees the
    // falling edge.
    rst_ni <= 1'b0;

    foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
    addr_ptr = 8'h00;
    page_ptr = 4'h0;
    paused   = 1'b0;

    // Bus bytes are written as reversed values through flip_byte, so the
    // command and data nibbles can be read directly.
    dir_tab = '{
      // Empty memory, screen corners and pixels below the screen.
      '{OP_READ,  1'b0, 8'h00,             7'd0,   7'd0,   1'b1, 2'd0},
      '{OP_READ,  1'b1, 8'hff,             7'd127, 7'd87,  1'b1, 2'd0},
      '{OP_READ,  1'b0, 8'h00,             7'd127, 7'd127, 1'b1, 2'd0},
      '{OP_READ,  1'b1, 8'hff,             7'd0,   7'd88,  1'b1, 2'd0},
      // Page 10, byte address 0xfe, then a command that is ignored.
      '{OP_WRITE, 1'b0, flip_byte(8'hba),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b0, flip_byte(8'h0f),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b0, flip_byte(8'h17),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b0, flip_byte({CMD_UNUSED, 4'hf}), 7'd0, 7'd0, 1'b0, 2'd0},
      // Data across the wrap of the byte address.
      '{OP_WRITE, 1'b1, flip_byte(8'hff),  7'd127, 7'd127, 1'b0, 2'd0},
      '{OP_WRITE, 1'b1, flip_byte(8'h80),  7'd127, 7'd127, 1'b0, 2'd0},
      '{OP_WRITE, 1'b1, flip_byte(8'h01),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b1, flip_byte(8'haa),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_READ,  1'b0, 8'h00,             7'd127, 7'd0,   1'b0, 2'd0},
      '{OP_READ,  1'b0, 8'h00,             7'd120, 7'd0,   1'b0, 2'd0},
      // Row 127 maps onto the written bytes 0xfe/0xff but lies off screen.
      '{OP_READ,  1'b1, 8'hff,             7'd127, 7'd127, 1'b1, 2'd0},
      // Page 9 holds the leftmost columns; column bits cleared to zero.
      '{OP_WRITE, 1'b0, flip_byte(8'hb9),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b0, flip_byte(8'h00),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b0, flip_byte(8'h10),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b1, 8'h00,             7'd127, 7'd127, 1'b0, 2'd0},
      '{OP_WRITE, 1'b1, 8'hff,             7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_READ,  1'b0, 8'h00,             7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_READ,  1'b0, 8'h00,             7'd7,   7'd0,   1'b0, 2'd0},
      '{OP_WRITE, 1'b0, flip_byte(8'hb0),  7'd0,   7'd0,   1'b0, 2'd0},
      '{OP_READ,  1'b1, 8'hff,             7'd64,  7'd40,  1'b0, 2'd0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send(dir_tab[i].mode, dir_tab[i].is_data, dir_tab[i].bus, dir_tab[i].x,
           dir_tab[i].y, dir_tab[i].chk, dir_tab[i].lvl);
    end

    // Random part, built from short sequences so that reads find data.
    while (sent_cnt < N_ITEMS) begin
      quiet = (sent_cnt >= N_ITEMS - QUIET_ITEMS);
      // Once, halfway, hold the bus until the block has answered everything.
      if (!paused && sent_cnt >= N_ITEMS / 2) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_levels.size() != 0) @(posedge clk_i);
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // Address setup followed by a burst of display data.
        write_byte(1'b0, {CMD_PAGE, 4'($urandom_range(0, 15))});
        write_byte(1'b0, {CMD_COL_LO, 4'($urandom_range(0, 15))});
        write_byte(1'b0, {CMD_COL_HI, 4'($urandom_range(0, 15))});
        n = $urandom_range(1, 12);
        repeat (n) write_byte(1'b1, 8'($urandom_range(0, 255)));
      end else if (kind < 6) begin
        // Lone command: mostly valid ones, sometimes pure noise.
        case ($urandom_range(0, 3))
          0:       write_byte(1'b0, {CMD_COL_LO, 4'($urandom_range(0, 15))});
          1:       write_byte(1'b0, {CMD_COL_HI, 4'($urandom_range(0, 15))});
          2:       write_byte(1'b0, {CMD_PAGE, 4'($urandom_range(0, 15))});
          default: write_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        endcase
      end else begin
        // Reads: half aimed at the bytes just written, the rest anywhere,
        // with some rows below the screen.
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) begin
            grp = page_ptr - PAGE_OFFSET;
            read_px(7'(SCREEN_WIDTH - 1 - (grp * 8 + $urandom_range(0, 7))),
                    7'((addr_ptr >> 1) - $urandom_range(0, 6)));
          end else if ($urandom_range(0, 9) == 0) begin
            read_px(7'($urandom_range(0, 127)), 7'($urandom_range(SCREEN_HEIGHT, 127)));
          end else begin
            read_px(7'($urandom_range(0, 127)), 7'($urandom_range(0, SCREEN_HEIGHT - 1)));
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_lcd_page_column_vram_controller OK");
    end else begin
      $display("tb_lcd_page_column_vram_controller NOT OK");
    end
    $finish;
  end

endmodule
